### rtl/mfgd_pkg.sv
package mfgd_pkg;

  // default screen size
  localparam int DISPLAY_WIDTH_DEF  = 128;
  localparam int DISPLAY_HEIGHT_DEF = 64;

  // frame store
  localparam int STORE_DEPTH = 1024;
  localparam int SD_W        = 10;

  // font geometry and special slots
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLON = 36;
  localparam int GLYPH_SPACE = 37;
  localparam int GLYPH_STAR  = 38;
  localparam int GLYPH_SLOTS = 39;
  localparam int ROM_DEPTH   = GLYPH_SLOTS * GLYPH_COLS;

  // command kinds
  localparam logic [2:0] KIND_CLEAR = 3'd0;
  localparam logic [2:0] KIND_PIXEL = 3'd1;
  localparam logic [2:0] KIND_GLYPH = 3'd2;
  localparam logic [2:0] KIND_HRUN  = 3'd3;
  localparam logic [2:0] KIND_VRUN  = 3'd4;
  localparam logic [2:0] KIND_READ  = 3'd5;

  typedef struct packed {
    logic load;       // capture the input beat
    logic sweep_wr;   // write zero at the sweep pointer
    logic col_next;   // advance to the next column
    logic page_init;  // first page of the current column
    logic page_next;  // advance to the next page
    logic mem_rd;     // read the byte under update
    logic mem_wr;     // write back the merged byte
    logic byte_rd;    // read for the read-byte command
    logic out_load;   // load the result register
  } mfgd_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       glyph_missing;
    logic       col_done;
    logic       col_skip;
    logic       page_last;
    logic       sweep_last;
    logic       out_free;
  } mfgd_stat_t;

  // column bytes, bit r is row r of the glyph
  localparam logic [7:0] GLYPH_ROM [ROM_DEPTH] = '{
    8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
    8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h21, 8'h41, 8'h49, 8'h4D, 8'h33,
    8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
    8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31, 8'h41, 8'h21, 8'h11, 8'h09, 8'h07,
    8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h46, 8'h49, 8'h49, 8'h29, 8'h1E,
    8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h36,
    8'h3E, 8'h41, 8'h41, 8'h41, 8'h22, 8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E,
    8'h7F, 8'h49, 8'h49, 8'h49, 8'h41, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h01,
    8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A, 8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F,
    8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h20, 8'h40, 8'h41, 8'h3F, 8'h01,
    8'h7F, 8'h08, 8'h14, 8'h22, 8'h41, 8'h7F, 8'h40, 8'h40, 8'h40, 8'h40,
    8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F, 8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F,
    8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h06,
    8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E, 8'h7F, 8'h09, 8'h09, 8'h19, 8'h66,
    8'h46, 8'h49, 8'h49, 8'h49, 8'h31, 8'h01, 8'h01, 8'h7F, 8'h01, 8'h01,
    8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F, 8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F,
    8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F, 8'h63, 8'h14, 8'h08, 8'h14, 8'h63,
    8'h07, 8'h08, 8'h70, 8'h08, 8'h07, 8'h61, 8'h51, 8'h49, 8'h45, 8'h43,
    8'h00, 8'h36, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2A, 8'h1C, 8'h7F, 8'h1C, 8'h2A
  };

  // {hit, slot}; lowercase folds onto uppercase
  function automatic logic [6:0] glyph_slot(input logic [7:0] c);
    logic [6:0] res;
    res = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, 6'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      res = {1'b1, 6'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      res = {1'b1, 6'(c - 8'h57)};
    end else if (c == 8'h3A) begin
      res = {1'b1, 6'(GLYPH_COLON)};
    end else if (c == 8'h20) begin
      res = {1'b1, 6'(GLYPH_SPACE)};
    end else if (c == 8'h2A) begin
      res = {1'b1, 6'(GLYPH_STAR)};
    end
    return res;
  endfunction

  function automatic logic [7:0] glyph_col(input logic [5:0] slot, input logic [2:0] col);
    logic [7:0] idx;
    idx = 8'(slot) * 8'(GLYPH_COLS) + 8'(col);
    return (idx < 8'(ROM_DEPTH)) ? GLYPH_ROM[idx] : 8'h00;
  endfunction

endpackage

### rtl/mono_framebuffer_glyph_drawer_core.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    kind, x_pos, y_pos, pixel_on, char_code,
//                                            line_length, read_index
// out      output     out_valid / out_ready  read_data, glyph_missing
//
// One command at a time. Every touched byte is a read then a write on the
// frame store, and every column also passes through the column state.
// After reset a sweep zeroes every byte of the store with in_ready low.
// A finished result waits in the output register; the next command is taken
// while it waits, and a command's own result stalls only on a full register.
module mono_framebuffer_glyph_drawer_core
  import mfgd_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic        [2:0] in_kind,
  input  logic signed [9:0] in_x_pos,
  input  logic signed [9:0] in_y_pos,
  input  logic              in_pixel_on,
  input  logic        [7:0] in_char_code,
  input  logic        [7:0] in_line_length,
  input  logic        [9:0] in_read_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic        [7:0] out_read_data,
  output logic              out_glyph_missing
);

  mfgd_cmd_t  cmd;
  mfgd_stat_t stat;

  mfgd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mfgd_datapath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (in_kind),
    .in_x_pos          (in_x_pos),
    .in_y_pos          (in_y_pos),
    .in_pixel_on       (in_pixel_on),
    .in_char_code      (in_char_code),
    .in_line_length    (in_line_length),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_glyph_missing (out_glyph_missing)
  );

`ifndef NO_ASSERTIONS
  // write-back always follows the read of the same byte
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> $past(cmd.mem_rd))
    else $error("write-back without preceding read");

  // a result is never loaded over one that is still waiting
  a_out_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // one command in flight: no accept right after an accept
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command taken while busy");
`endif

endmodule

### rtl/mfgd_ctrl.sv
module mfgd_ctrl
  import mfgd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  mfgd_stat_t stat,
  output mfgd_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_SWEEP = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_DISP  = 8'b0000_0100,
    ST_COL   = 8'b0000_1000,
    ST_RD    = 8'b0001_0000,
    ST_WR    = 8'b0010_0000,
    ST_RDB   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   res_pend_r, res_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      res_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      res_pend_r <= res_pend_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    res_pend_nxt = res_pend_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          // reset sweep returns quietly, a clear command owes a result
          state_nxt    = res_pend_r ? ST_FIN : ST_IDLE;
          res_pend_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (stat.kind) inside
          KIND_CLEAR: begin
            res_pend_nxt = 1'b1;
            state_nxt    = ST_SWEEP;
          end
          KIND_READ: state_nxt = ST_RDB;
          KIND_GLYPH: state_nxt = stat.glyph_missing ? ST_FIN : ST_COL;
          KIND_PIXEL, KIND_HRUN, KIND_VRUN: state_nxt = ST_COL;
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_COL: begin
        if (stat.col_done) begin
          state_nxt = ST_FIN;
        end else if (stat.col_skip) begin
          cmd.col_next = 1'b1;
        end else begin
          cmd.page_init = 1'b1;
          state_nxt     = ST_RD;
        end
      end
      ST_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_WR;
      end
      ST_WR: begin
        cmd.mem_wr = 1'b1;
        if (stat.page_last) begin
          cmd.col_next = 1'b1;
          state_nxt    = ST_COL;
        end else begin
          cmd.page_next = 1'b1;
          state_nxt     = ST_RD;
        end
      end
      ST_RDB: begin
        cmd.byte_rd = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_SWEEP;
    endcase
  end

endmodule

### rtl/mfgd_datapath.sv
module mfgd_datapath
  import mfgd_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mfgd_cmd_t         cmd,
  output mfgd_stat_t        stat,
  input  logic        [2:0] in_kind,
  input  logic signed [9:0] in_x_pos,
  input  logic signed [9:0] in_y_pos,
  input  logic              in_pixel_on,
  input  logic        [7:0] in_char_code,
  input  logic        [7:0] in_line_length,
  input  logic        [9:0] in_read_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic        [7:0] out_read_data,
  output logic              out_glyph_missing
);

  localparam int PAGES      = (DISPLAY_HEIGHT + 7) / 8;
  localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int XW         = $clog2(DISPLAY_WIDTH);
  localparam int USED_BYTES = DISPLAY_WIDTH * PAGES;
  localparam int AW_USED    = $clog2(USED_BYTES);
  localparam int CALC_W     = (AW_USED > SD_W) ? AW_USED : SD_W;
  localparam logic signed [10:0] W_S     = 11'(DISPLAY_WIDTH);
  localparam logic signed [10:0] H_S     = 11'(DISPLAY_HEIGHT);
  localparam logic signed [10:0] PLAST_S = 11'(PAGES - 1);

  logic [7:0] mem [STORE_DEPTH];

  logic        [2:0]        kind_r;
  logic signed [9:0]        x_r, y_r;
  logic                     on_r;
  logic        [7:0]        len_r;
  logic        [9:0]        ridx_r;
  logic        [5:0]        slot_r;
  logic                     miss_r;
  logic        [7:0]        col_r;
  logic        [PAGE_W-1:0] page_r;
  logic        [SD_W-1:0]   sw_r;
  logic        [7:0]        rdata_r;
  logic        [7:0]        out_data_r;
  logic                     out_miss_r;
  logic                     out_valid_r;

  logic        [6:0]        slot_w;
  logic        [7:0]        ncols, hgt, col_bits;
  logic signed [10:0]       x_cur, y11, y_end, yf, ye;
  logic        [PAGE_W-1:0] pg_first, pg_last;
  logic        [CALC_W-1:0] addr_full;
  logic                     addr_ok, rd_ok;
  logic        [7:0]        mask, val, new_byte;
  logic                     we, re;
  logic        [SD_W-1:0]   waddr, raddr;
  logic        [7:0]        wdata;

  assign slot_w   = glyph_slot(in_char_code);
  assign col_bits = glyph_col(slot_r, col_r[2:0]);

  always_comb begin
    unique case (kind_r) inside
      KIND_GLYPH: begin
        ncols = 8'(GLYPH_COLS);
        hgt   = 8'(GLYPH_ROWS);
      end
      KIND_HRUN: begin
        ncols = len_r;
        hgt   = 8'd1;
      end
      KIND_VRUN: begin
        ncols = 8'd1;
        hgt   = len_r;
      end
      default: begin
        ncols = 8'd1;
        hgt   = 8'd1;
      end
    endcase
  end

  // current column and the span of pages touched by its segment
  assign x_cur    = {x_r[9], x_r} + $signed({3'b000, col_r});
  assign y11      = {y_r[9], y_r};
  assign y_end    = y11 + $signed({3'b000, hgt}) - 11'sd1;
  assign yf       = y11 >>> 3;
  assign ye       = y_end >>> 3;
  assign pg_first = (yf < 11'sd0) ? '0 : yf[PAGE_W-1:0];
  assign pg_last  = (ye > PLAST_S) ? PAGE_W'(PAGES - 1) : ye[PAGE_W-1:0];

  assign addr_full = CALC_W'(x_cur[XW-1:0]) + CALC_W'(page_r) * CALC_W'(DISPLAY_WIDTH);
  assign addr_ok   = (addr_full >> SD_W) == '0;
  assign rd_ok     = 32'(ridx_r) < USED_BYTES;

  // per-bit merge mask for the byte at page_r
  always_comb begin
    logic signed [10:0] row;
    logic signed [10:0] di;
    mask = '0;
    val  = '0;
    for (int b = 0; b < 8; b++) begin
      row = $signed({{(8 - PAGE_W){1'b0}}, page_r, 3'(b)});
      di  = row - y11;
      mask[b] = (di >= 11'sd0) && (di < $signed({3'b000, hgt})) && (row < H_S);
      case (kind_r)
        KIND_GLYPH: val[b] = col_bits[di[2:0]];
        KIND_PIXEL: val[b] = on_r;
        default:    val[b] = 1'b1;
      endcase
    end
  end

  assign new_byte = (rdata_r & ~mask) | (val & mask);

  assign we    = cmd.sweep_wr | (cmd.mem_wr & addr_ok);
  assign waddr = cmd.sweep_wr ? sw_r : addr_full[SD_W-1:0];
  assign wdata = cmd.sweep_wr ? 8'h00 : new_byte;
  assign re    = cmd.mem_rd | cmd.byte_rd;
  assign raddr = cmd.byte_rd ? ridx_r : addr_full[SD_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      x_r    <= in_x_pos;
      y_r    <= in_y_pos;
      on_r   <= in_pixel_on;
      len_r  <= in_line_length;
      ridx_r <= in_read_index;
      slot_r <= slot_w[5:0];
      miss_r <= (in_kind == KIND_GLYPH) && !slot_w[6];
    end
    if (cmd.load) begin
      col_r <= '0;
    end else if (cmd.col_next) begin
      col_r <= col_r + 8'd1;
    end
    if (cmd.page_init) begin
      page_r <= pg_first;
    end else if (cmd.page_next) begin
      page_r <= page_r + PAGE_W'(1);
    end
    if (cmd.out_load) begin
      out_data_r <= (kind_r == KIND_READ && rd_ok) ? rdata_r : 8'h00;
      out_miss_r <= miss_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep_wr) begin
        sw_r <= sw_r + SD_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat               = '0;
    stat.kind          = kind_r;
    stat.glyph_missing = miss_r;
    stat.col_done      = (col_r == ncols);
    stat.col_skip      = (x_cur < 11'sd0) || (x_cur >= W_S) || (hgt == 8'd0) ||
                         (y_end < 11'sd0) || (y11 >= H_S);
    stat.page_last     = (page_r == pg_last);
    stat.sweep_last    = (sw_r == SD_W'(STORE_DEPTH - 1));
    stat.out_free      = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_data_r;
  assign out_glyph_missing = out_miss_r;

endmodule

### bench/mono_framebuffer_glyph_drawer_core_tb.sv
module mono_framebuffer_glyph_drawer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfgd_pkg::*;

  localparam int FB_W     = DISPLAY_WIDTH_DEF;
  localparam int FB_H     = DISPLAY_HEIGHT_DEF;
  localparam int FB_BYTES = FB_W * ((FB_H + 7) / 8);

  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam int RANDOM_CMDS = 750;
  localparam int PHASE1_AT   = 280;
  localparam int PHASE2_AT   = 530;
  localparam int HOLD_AT     = 560;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 1100;

  // column bytes of the 5x7 font, bit r is glyph row r
  localparam logic [7:0] FONT_COLS [GLYPH_SLOTS * GLYPH_COLS] = '{
    8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
    8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h21, 8'h41, 8'h49, 8'h4D, 8'h33,
    8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
    8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31, 8'h41, 8'h21, 8'h11, 8'h09, 8'h07,
    8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h46, 8'h49, 8'h49, 8'h29, 8'h1E,
    8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h36,
    8'h3E, 8'h41, 8'h41, 8'h41, 8'h22, 8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E,
    8'h7F, 8'h49, 8'h49, 8'h49, 8'h41, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h01,
    8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A, 8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F,
    8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h20, 8'h40, 8'h41, 8'h3F, 8'h01,
    8'h7F, 8'h08, 8'h14, 8'h22, 8'h41, 8'h7F, 8'h40, 8'h40, 8'h40, 8'h40,
    8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F, 8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F,
    8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h06,
    8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E, 8'h7F, 8'h09, 8'h09, 8'h19, 8'h66,
    8'h46, 8'h49, 8'h49, 8'h49, 8'h31, 8'h01, 8'h01, 8'h7F, 8'h01, 8'h01,
    8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F, 8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F,
    8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F, 8'h63, 8'h14, 8'h08, 8'h14, 8'h63,
    8'h07, 8'h08, 8'h70, 8'h08, 8'h07, 8'h61, 8'h51, 8'h49, 8'h45, 8'h43,
    8'h00, 8'h36, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2A, 8'h1C, 8'h7F, 8'h1C, 8'h2A
  };

  typedef struct {
    logic        [2:0] kind;
    logic signed [9:0] x_pos;
    logic signed [9:0] y_pos;
    logic              pixel_on;
    logic        [7:0] char_code;
    logic        [7:0] line_length;
    logic        [9:0] read_index;
    bit                wait_idle;  // hold back until every result is in
  } draw_cmd_t;

  typedef struct {
    logic [7:0] read_data;
    logic       glyph_missing;
  } draw_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic        [2:0] in_kind = '0;
  logic signed [9:0] in_x_pos = '0;
  logic signed [9:0] in_y_pos = '0;
  logic              in_pixel_on = 1'b0;
  logic        [7:0] in_char_code = '0;
  logic        [7:0] in_line_length = '0;
  logic        [9:0] in_read_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic        [7:0] out_read_data;
  logic              out_glyph_missing;

  draw_cmd_t    cmd_q[$];
  draw_result_t expected_q[$];
  logic [7:0]   shadow_fb [STORE_DEPTH] = '{default: 8'h00};

  int cmds_taken = 0;     // updated by the monitor, nonblocking
  int results_taken = 0;
  int owed = 0;
  int errors = 0;
  int total_cmds = 0;
  int last_x = 0;
  int last_y = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  mono_framebuffer_glyph_drawer_core DUT (.*);

  always #5 clk = ~clk;

  function automatic void plot(int x, int y, logic on);
    int addr;
    if (x < 0 || x >= FB_W || y < 0 || y >= FB_H) return;
    addr = x + (y / 8) * FB_W;
    if (addr >= STORE_DEPTH) return;
    shadow_fb[addr][y % 8] = on;
  endfunction

  function automatic int font_slot(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "Z") return 10 + int'(c - "A");
    if (c >= "a" && c <= "z") return 10 + int'(c - "a");
    if (c == ":") return GLYPH_COLON;
    if (c == " ") return GLYPH_SPACE;
    if (c == "*") return GLYPH_STAR;
    return -1;
  endfunction

  function automatic draw_result_t render_cmd(draw_cmd_t c);
    draw_result_t r;
    int x, y, slot;
    logic [7:0] bits;
    r = '{read_data: 8'h00, glyph_missing: 1'b0};
    x = int'(c.x_pos);
    y = int'(c.y_pos);
    case (c.kind)
      KIND_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      KIND_PIXEL: plot(x, y, c.pixel_on);
      KIND_GLYPH: begin
        slot = font_slot(c.char_code);
        if (slot < 0) begin
          r.glyph_missing = 1'b1;
        end else begin
          for (int col = 0; col < GLYPH_COLS; col++) begin
            bits = FONT_COLS[slot * GLYPH_COLS + col];
            for (int row = 0; row < GLYPH_ROWS; row++) plot(x + col, y + row, bits[row]);
          end
        end
      end
      KIND_HRUN: for (int i = 0; i < int'(c.line_length); i++) plot(x + i, y, 1'b1);
      KIND_VRUN: for (int i = 0; i < int'(c.line_length); i++) plot(x, y + i, 1'b1);
      KIND_READ: begin
        if (int'(c.read_index) < FB_BYTES && int'(c.read_index) < STORE_DEPTH)
          r.read_data = shadow_fb[c.read_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_cmd(logic [2:0] kind, int x, int y, logic on, logic [7:0] code,
                           logic [7:0] len, logic [9:0] idx, bit wait_idle = 1'b0);
    draw_cmd_t c;
    c.kind        = kind;
    c.x_pos       = 10'(x);
    c.y_pos       = 10'(y);
    c.pixel_on    = on;
    c.char_code   = code;
    c.line_length = len;
    c.read_index  = idx;
    c.wait_idle   = wait_idle;
    cmd_q.push_back(c);
    total_cmds++;
  endtask

  // mostly drawing near the screen followed by reads around the last touched spot
  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int pick, sel, x, y;
    pick = $urandom_range(99);
    if (pick < 2) c.kind = KIND_CLEAR;
    else if (pick < 20) c.kind = KIND_PIXEL;
    else if (pick < 36) c.kind = KIND_GLYPH;
    else if (pick < 46) c.kind = KIND_HRUN;
    else if (pick < 56) c.kind = KIND_VRUN;
    else if (pick < 97) c.kind = KIND_READ;
    else c.kind = (pick == 97) ? KIND_SPARE_LO : KIND_SPARE_HI;
    c.x_pos = ($urandom_range(4) == 0) ? 10'($urandom) : 10'($urandom_range(FB_W + 7) - 4);
    c.y_pos = ($urandom_range(4) == 0) ? 10'($urandom) : 10'($urandom_range(FB_H + 7) - 4);
    c.pixel_on = 1'($urandom_range(1));
    if ($urandom_range(4) == 0) begin
      c.char_code = 8'($urandom);
    end else begin
      sel = $urandom_range(64);
      if (sel < 10) c.char_code = 8'("0" + sel);
      else if (sel < 36) c.char_code = 8'("A" + sel - 10);
      else if (sel < 62) c.char_code = 8'("a" + sel - 36);
      else if (sel == 62) c.char_code = ":";
      else if (sel == 63) c.char_code = " ";
      else c.char_code = "*";
    end
    c.line_length = ($urandom_range(9) < 7) ? 8'($urandom_range(40)) : 8'($urandom);
    if ($urandom_range(9) < 7)
      c.read_index = 10'(last_x + $urandom_range(5) + (last_y / 8 + $urandom_range(1)) * FB_W);
    else
      c.read_index = 10'($urandom);
    c.wait_idle = 1'b0;
    x = int'(c.x_pos);
    y = int'(c.y_pos);
    if (c.kind inside {KIND_PIXEL, KIND_GLYPH, KIND_HRUN, KIND_VRUN} &&
        x >= 0 && x < FB_W && y >= 0 && y < FB_H) begin
      last_x = x;
      last_y = y;
    end
    return c;
  endfunction

  task automatic report(string field, int want, int got);
    errors++;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
  endtask

  // driver
  always @(posedge clk) begin
    draw_cmd_t nxt;
    logic present;
    int send_idle;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      send_idle = (cmds_taken < PHASE1_AT) ? 33 : (cmds_taken < PHASE2_AT) ? 86 : 0;
      present = 1'b0;
      if (cmd_q.size() > 0) begin
        if (cmd_q[0].wait_idle) present = !in_valid && owed == 0;
        else present = $urandom_range(99) >= send_idle;
      end
      if (present) begin
        nxt = cmd_q.pop_front();
        in_kind        <= nxt.kind;
        in_x_pos       <= nxt.x_pos;
        in_y_pos       <= nxt.y_pos;
        in_pixel_on    <= nxt.pixel_on;
        in_char_code   <= nxt.char_code;
        in_line_length <= nxt.line_length;
        in_read_index  <= nxt.read_index;
      end
      in_valid <= present;
    end
  end

  // receiver, with one long hold-off once the sender runs flat out
  always @(posedge clk) begin
    int recv_idle;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && results_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      recv_idle = (cmds_taken < PHASE1_AT) ? 86 : (cmds_taken < PHASE2_AT) ? 33 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(99) >= recv_idle;
      end
    end
  end

  // monitor: results are checked before the beat taken at the same edge is predicted
  always @(posedge clk) begin
    draw_result_t want;
    draw_cmd_t seen;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, read_data %0h glyph_missing %0b",
                   $time, out_read_data, out_glyph_missing);
        end else begin
          want = expected_q.pop_front();
          if (out_read_data !== want.read_data)
            report("read_data", int'(want.read_data), int'(out_read_data));
          if (out_glyph_missing !== want.glyph_missing)
            report("glyph_missing", int'(want.glyph_missing), int'(out_glyph_missing));
        end
        results_taken <= results_taken + 1;
      end
      if (in_valid && in_ready) begin
        seen.kind        = in_kind;
        seen.x_pos       = in_x_pos;
        seen.y_pos       = in_y_pos;
        seen.pixel_on    = in_pixel_on;
        seen.char_code   = in_char_code;
        seen.line_length = in_line_length;
        seen.read_index  = in_read_index;
        seen.wait_idle   = 1'b0;
        expected_q.push_back(render_cmd(seen));
        cmds_taken <= cmds_taken + 1;
      end
      owed <= expected_q.size();
    end
  end

  initial begin
    draw_cmd_t c;
    // corners, clipping on every edge, glyph specials, runs and spare kinds
    queue_cmd(KIND_READ, 0, 0, 1'b0, 8'h00, 8'd0, 10'd0);
    queue_cmd(KIND_PIXEL, 0, 0, 1'b1, 8'h00, 8'd0, 10'd0);
    queue_cmd(KIND_PIXEL, FB_W - 1, FB_H - 1, 1'b1, 8'h00, 8'd0, 10'd0);
    queue_cmd(KIND_PIXEL, FB_W, 0, 1'b1, 8'h00, 8'd0, 10'd0);
    queue_cmd(KIND_PIXEL, 0, FB_H, 1'b1, 8'h00, 8'd0, 10'd0);
    queue_cmd(KIND_PIXEL, -512, -512, 1'b1, 8'h00, 8'd0, 10'd0);
    queue_cmd(KIND_PIXEL, 511, 511, 1'b1, 8'h00, 8'd0, 10'd0);
    queue_cmd(KIND_READ, 0, 0, 1'b0, 8'h00, 8'd0, 10'd1023);
    queue_cmd(KIND_READ, 0, 0, 1'b0, 8'h00, 8'd0, 10'(FB_W));
    queue_cmd(KIND_PIXEL, 0, 0, 1'b0, 8'h00, 8'd0, 10'd0);
    queue_cmd(KIND_READ, 0, 0, 1'b0, 8'h00, 8'd0, 10'd0);
    queue_cmd(KIND_GLYPH, 10, 3, 1'b0, "A", 8'd0, 10'd0);
    queue_cmd(KIND_READ, 0, 0, 1'b0, 8'h00, 8'd0, 10'(FB_W + 10), 1'b1);
    queue_cmd(KIND_GLYPH, FB_W - 3, FB_H - 4, 1'b0, "z", 8'd0, 10'd0);
    queue_cmd(KIND_READ, 0, 0, 1'b0, 8'h00, 8'd0, 10'(FB_BYTES - 3));
    queue_cmd(KIND_GLYPH, 10, 3, 1'b1, 8'hFF, 8'd0, 10'd0);
    queue_cmd(KIND_GLYPH, -2, -3, 1'b0, ":", 8'd0, 10'd0);
    queue_cmd(KIND_GLYPH, 40, 8, 1'b0, " ", 8'd0, 10'd0);
    queue_cmd(KIND_GLYPH, 50, 20, 1'b0, "*", 8'd0, 10'd0);
    queue_cmd(KIND_HRUN, FB_W - 8, 8, 1'b0, 8'h00, 8'd255, 10'd0);
    queue_cmd(KIND_HRUN, 0, 8, 1'b0, 8'h00, 8'd0, 10'd0);
    queue_cmd(KIND_VRUN, 5, -10, 1'b0, 8'h00, 8'd255, 10'd0);
    queue_cmd(KIND_READ, 0, 0, 1'b0, 8'h00, 8'd0, 10'(FB_W + 5));
    queue_cmd(KIND_SPARE_LO, 3, 3, 1'b1, "A", 8'd10, 10'd0);
    queue_cmd(KIND_SPARE_HI, -1, -1, 1'b1, 8'hFF, 8'd255, 10'd1023);
    queue_cmd(KIND_CLEAR, 0, 0, 1'b0, 8'h00, 8'd0, 10'd0, 1'b1);
    queue_cmd(KIND_READ, 0, 0, 1'b0, 8'h00, 8'd0, 10'(FB_W + 10));
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      c = random_cmd();
      if (i % 150 == 149) c.wait_idle = 1'b1;
      cmd_q.push_back(c);
      total_cmds++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (cmds_taken < total_cmds || owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_q.size());
    end
    if (errors == 0) begin
      $display("mono_framebuffer_glyph_drawer_core_tb: PASS");
    end else begin
      $display("mono_framebuffer_glyph_drawer_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("%0t: timeout", $time);
    $display("mono_framebuffer_glyph_drawer_core_tb: FAIL");
    $finish;
  end

endmodule
